[design/lfsa_pkg.sv]
// shared types, constants and codes for the largest-fit segment allocator
package lfsa_pkg;

    localparam int DATA_W     = 32;
    localparam int SEG_DEPTH  = 64;
    localparam int SEG_IDX_W  = 6;
    localparam int REQ_DEPTH  = 1024;
    localparam int REQ_IDX_W  = 10;
    localparam int ADDR_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [DATA_W-1:0] CELLS_MAX    = 32'hFFFF_FFFE;
    localparam logic [DATA_W-1:0] MEM_SIZE_RST = 32'd1024;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_SCAN,
        ST_A_DRAIN,
        ST_A_DECIDE,
        ST_A_SPLIT,
        ST_F_RD,
        ST_F_CHK,
        ST_F_SCAN1,
        ST_F_DRAIN1,
        ST_F_MID,
        ST_F_SCAN2,
        ST_F_DRAIN2,
        ST_F_MERGE,
        ST_F_SLOT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_A_DECIDE,
        OP_A_SPLIT,
        OP_F_CHECK,
        OP_F_MERGE,
        OP_F_SLOT
    } dp_op_t;

    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_ALLOC,
        SCAN_HIT,
        SCAN_RIGHT
    } scan_t;

    typedef struct packed {
        dp_op_t                 op;
        scan_t                  scan;
        logic [SEG_IDX_W-1:0]   idx;
        logic [REQ_IDX_W-1:0]   clr_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic               alloc_split;
        logic               hit_found;
        logic               req_live;
        logic               out_free;
        logic [DATA_W-1:0]  mem_size;
    } dp_stat_t;

endpackage

[design/lfsa_ram.sv]
// generic single-write, single-read ram with registered read data
module lfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/lfsa_ctrl.sv]
// sequencer for clear sweep, allocate scan and free scans
module lfsa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              s_valid,
    input  logic              s_opcode,
    output logic              s_ready,
    input  lfsa_pkg::dp_stat_t stat,
    output lfsa_pkg::dp_cmd_t  cmd
);
    import lfsa_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [SEG_IDX_W-1:0] idx_reg, idx_next;
    logic [REQ_IDX_W-1:0] clr_reg, clr_next;
    logic idx_last;

    assign idx_last = (idx_reg == SEG_IDX_W'(SEG_DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        clr_next    = clr_reg;
        s_ready     = 1'b0;
        cmd.op      = OP_NONE;
        cmd.scan    = SCAN_NONE;
        cmd.idx     = idx_reg;
        cmd.clr_idx = clr_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.op   = OP_CLEAR;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == REQ_IDX_W'(REQ_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = !cfg_we;
                idx_next = '0;
                if (s_valid && !cfg_we) begin
                    cmd.op     = OP_LOAD;
                    state_next = (s_opcode == OPC_FREE) ? ST_F_RD : ST_A_SCAN;
                end
            end
            ST_A_SCAN: begin
                cmd.scan = SCAN_ALLOC;
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    state_next = ST_A_DRAIN;
                end
            end
            ST_A_DRAIN: state_next = ST_A_DECIDE;
            ST_A_DECIDE: begin
                if (stat.out_free) begin
                    cmd.op     = OP_A_DECIDE;
                    state_next = stat.alloc_split ? ST_A_SPLIT : ST_IDLE;
                end
            end
            ST_A_SPLIT: begin
                cmd.op     = OP_A_SPLIT;
                state_next = ST_IDLE;
            end
            ST_F_RD: state_next = ST_F_CHK;
            ST_F_CHK: begin
                cmd.op     = OP_F_CHECK;
                idx_next   = '0;
                state_next = stat.req_live ? ST_F_SCAN1 : ST_F_SLOT;
            end
            ST_F_SCAN1: begin
                cmd.scan = SCAN_HIT;
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    state_next = ST_F_DRAIN1;
                end
            end
            ST_F_DRAIN1: state_next = ST_F_MID;
            ST_F_MID: begin
                idx_next   = '0;
                state_next = stat.hit_found ? ST_F_SCAN2 : ST_F_SLOT;
            end
            ST_F_SCAN2: begin
                cmd.scan = SCAN_RIGHT;
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    state_next = ST_F_DRAIN2;
                end
            end
            ST_F_DRAIN2: state_next = ST_F_MERGE;
            ST_F_MERGE: begin
                cmd.op     = OP_F_MERGE;
                state_next = ST_F_SLOT;
            end
            ST_F_SLOT: begin
                cmd.op     = OP_F_SLOT;
                state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
        if (cfg_we) begin
            state_next = ST_CLEAR;
            clr_next   = '0;
        end
    end

endmodule

[design/lfsa_dp.sv]
// segment table, request table, scan trackers and result register
module lfsa_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lfsa_pkg::DATA_W-1:0]       cfg_wdata,
    input  lfsa_pkg::dp_cmd_t                 cmd,
    output lfsa_pkg::dp_stat_t                stat,
    input  logic [lfsa_pkg::DATA_W-1:0]       s_alloc_size,
    input  logic [lfsa_pkg::REQ_IDX_W-1:0]    s_free_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lfsa_pkg::STATUS_W-1:0]     m_status,
    output logic [lfsa_pkg::DATA_W-1:0]       m_position,
    output logic [lfsa_pkg::REQ_IDX_W-1:0]    m_request_index
);
    import lfsa_pkg::*;

    localparam int REQ_W = DATA_W + 1;

    logic [DATA_W-1:0]    mem_size_reg, cells;
    logic [SEG_DEPTH-1:0] in_use_reg, free_reg;
    logic [REQ_IDX_W-1:0] slot_reg, fi_reg;
    logic [DATA_W-1:0]    size_reg;

    // scan pipeline
    scan_t                scan_d_reg;
    logic [SEG_IDX_W-1:0] eidx_reg;

    // allocate trackers
    logic                 best_found_reg, spare_found_reg;
    logic [SEG_IDX_W-1:0] best_idx_reg, spare_idx_reg;
    logic [DATA_W-1:0]    best_size_reg, best_start_reg;

    // free trackers
    logic [DATA_W-1:0]    target_reg, hit_end_reg, left_start_reg, right_end_reg;
    logic                 hit_found_reg, left_found_reg, right_found_reg;
    logic [SEG_IDX_W-1:0] hit_idx_reg, left_idx_reg, right_idx_reg;

    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [DATA_W-1:0]     m_position_reg;
    logic [REQ_IDX_W-1:0]  m_req_reg;

    // ram ports
    logic                 st_we, en_we, rq_we;
    logic [SEG_IDX_W-1:0] st_waddr, en_waddr;
    logic [DATA_W-1:0]    st_wdata, en_wdata, st_rdata, en_rdata;
    logic [REQ_IDX_W-1:0] rq_waddr;
    logic [REQ_W-1:0]     rq_wdata, rq_rdata;

    logic [DATA_W-1:0] seg_len, split_end;
    logic              e_used, e_free;
    logic              alloc_fail, alloc_exact, alloc_ok, alloc_split, out_free;
    logic [STATUS_W-1:0] alloc_status;

    assign cells = (mem_size_reg > CELLS_MAX) ? CELLS_MAX : mem_size_reg;

    lfsa_ram #(.WIDTH(DATA_W), .DEPTH(SEG_DEPTH)) u_seg_start (
        .clk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(cmd.idx), .rdata(st_rdata)
    );

    lfsa_ram #(.WIDTH(DATA_W), .DEPTH(SEG_DEPTH)) u_seg_end (
        .clk(aclk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
        .raddr(cmd.idx), .rdata(en_rdata)
    );

    lfsa_ram #(.WIDTH(REQ_W), .DEPTH(REQ_DEPTH)) u_req (
        .clk(aclk), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
        .raddr(fi_reg), .rdata(rq_rdata)
    );

    assign seg_len   = en_rdata - st_rdata;
    assign split_end = best_start_reg + size_reg;
    assign e_used    = in_use_reg[eidx_reg];
    assign e_free    = free_reg[eidx_reg];

    assign alloc_fail  = (size_reg == '0) || !best_found_reg || (best_size_reg < size_reg);
    assign alloc_exact = (best_size_reg == size_reg);
    assign alloc_ok    = !alloc_fail && (alloc_exact || spare_found_reg);
    assign alloc_split = !alloc_fail && !alloc_exact && spare_found_reg;
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        if (alloc_fail) begin
            alloc_status = STAT_NOFIT;
        end else if (!alloc_ok) begin
            alloc_status = STAT_FULL;
        end else begin
            alloc_status = STAT_OK;
        end
    end

    always_comb begin
        st_we    = 1'b0;
        en_we    = 1'b0;
        rq_we    = 1'b0;
        st_waddr = '0;
        en_waddr = '0;
        st_wdata = '0;
        en_wdata = '0;
        rq_waddr = slot_reg;
        rq_wdata = '0;
        case (cmd.op)
            OP_CLEAR: begin
                st_we    = 1'b1;
                en_we    = 1'b1;
                st_wdata = DATA_W'(1);
                en_wdata = cells + DATA_W'(1);
                rq_we    = 1'b1;
                rq_waddr = cmd.clr_idx;
            end
            OP_A_DECIDE: begin
                rq_we    = 1'b1;
                rq_wdata = {alloc_ok, alloc_ok ? best_start_reg : DATA_W'(0)};
                if (alloc_split) begin
                    st_we    = 1'b1;
                    st_waddr = spare_idx_reg;
                    st_wdata = best_start_reg;
                    en_we    = 1'b1;
                    en_waddr = spare_idx_reg;
                    en_wdata = split_end;
                end
            end
            OP_A_SPLIT: begin
                st_we    = 1'b1;
                st_waddr = best_idx_reg;
                st_wdata = split_end;
            end
            OP_F_CHECK: begin
                rq_we    = rq_rdata[DATA_W];
                rq_waddr = fi_reg;
                rq_wdata = {1'b0, rq_rdata[DATA_W-1:0]};
            end
            OP_F_MERGE: begin
                st_we    = 1'b1;
                st_waddr = hit_idx_reg;
                st_wdata = left_found_reg ? left_start_reg : target_reg;
                en_we    = 1'b1;
                en_waddr = hit_idx_reg;
                en_wdata = right_found_reg ? right_end_reg : hit_end_reg;
            end
            OP_F_SLOT: rq_we = 1'b1;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg <= MEM_SIZE_RST;
            in_use_reg   <= SEG_DEPTH'(1);
            free_reg     <= SEG_DEPTH'(1);
            slot_reg     <= '0;
            m_valid_reg  <= 1'b0;
            scan_d_reg   <= SCAN_NONE;
        end else begin
            scan_d_reg <= cmd.scan;
            if (!cfg_we && cmd.op == OP_A_DECIDE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                mem_size_reg <= cfg_wdata;
                in_use_reg   <= SEG_DEPTH'(cfg_wdata != '0);
                free_reg     <= SEG_DEPTH'(cfg_wdata != '0);
                slot_reg     <= '0;
            end else begin
                case (cmd.op)
                    OP_A_DECIDE: begin
                        slot_reg <= slot_reg + REQ_IDX_W'(1);
                        if (alloc_ok && alloc_exact) begin
                            free_reg[best_idx_reg] <= 1'b0;
                        end
                        if (alloc_split) begin
                            in_use_reg[spare_idx_reg] <= 1'b1;
                            free_reg[spare_idx_reg]   <= 1'b0;
                        end
                    end
                    OP_F_MERGE: begin
                        free_reg[hit_idx_reg] <= 1'b1;
                        if (left_found_reg) begin
                            in_use_reg[left_idx_reg] <= 1'b0;
                            free_reg[left_idx_reg]   <= 1'b0;
                        end
                        if (right_found_reg) begin
                            in_use_reg[right_idx_reg] <= 1'b0;
                            free_reg[right_idx_reg]   <= 1'b0;
                        end
                    end
                    OP_F_SLOT: slot_reg <= slot_reg + REQ_IDX_W'(1);
                    default: ;
                endcase
            end
        end
    end

    // payload and trackers
    always_ff @(posedge aclk) begin
        eidx_reg <= cmd.idx;
        if (cmd.op == OP_LOAD) begin
            size_reg        <= s_alloc_size;
            fi_reg          <= s_free_index;
            best_found_reg  <= 1'b0;
            spare_found_reg <= 1'b0;
            hit_found_reg   <= 1'b0;
            left_found_reg  <= 1'b0;
            right_found_reg <= 1'b0;
        end
        if (cmd.op == OP_A_DECIDE) begin
            m_status_reg   <= alloc_status;
            m_position_reg <= alloc_ok ? best_start_reg : DATA_W'(0);
            m_req_reg      <= slot_reg;
        end
        if (cmd.op == OP_F_CHECK) begin
            target_reg <= rq_rdata[DATA_W-1:0];
        end
        case (scan_d_reg)
            SCAN_ALLOC: begin
                if (!e_used && !spare_found_reg) begin
                    spare_found_reg <= 1'b1;
                    spare_idx_reg   <= eidx_reg;
                end
                if (e_used && e_free && (!best_found_reg || seg_len > best_size_reg ||
                        (seg_len == best_size_reg && st_rdata < best_start_reg))) begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= eidx_reg;
                    best_size_reg  <= seg_len;
                    best_start_reg <= st_rdata;
                end
            end
            SCAN_HIT: begin
                if (e_used && !e_free && st_rdata == target_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= eidx_reg;
                    hit_end_reg   <= en_rdata;
                end
                if (e_used && e_free && en_rdata == target_reg) begin
                    left_found_reg <= 1'b1;
                    left_idx_reg   <= eidx_reg;
                    left_start_reg <= st_rdata;
                end
            end
            SCAN_RIGHT: begin
                if (e_used && e_free && st_rdata == hit_end_reg) begin
                    right_found_reg <= 1'b1;
                    right_idx_reg   <= eidx_reg;
                    right_end_reg   <= en_rdata;
                end
            end
            default: ;
        endcase
    end

    assign stat.alloc_split = alloc_split;
    assign stat.hit_found   = hit_found_reg;
    assign stat.req_live    = rq_rdata[DATA_W];
    assign stat.out_free    = out_free;
    assign stat.mem_size    = mem_size_reg;

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_position      = m_position_reg;
    assign m_request_index = m_req_reg;

endmodule

[design/largest_fit_segment_allocator.sv]
// top level of the largest-fit segment allocator: apb register, sequencer, datapath
// allocate item: result after a 64-entry scan through the registered ram read, a drain
//   state and a decide state; the next item is taken after that, or after a split state on a split
// free item: no result; two 64-entry scans when a live item's segment is found, one when it
//   is not, none when the index is dead
// a result waits in the output register while the next item is taken; decide stalls while it is full
// reset and every cell count write start a clearing pass over the 1024-entry request
//   table, no item is accepted during it
module largest_fit_segment_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfsa_pkg::ADDR_W-1:0]       paddr,
    input  logic [lfsa_pkg::DATA_W-1:0]       pwdata,
    output logic [lfsa_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    // request items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [lfsa_pkg::DATA_W-1:0]       s_alloc_size,
    input  logic [lfsa_pkg::REQ_IDX_W-1:0]    s_free_index,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lfsa_pkg::STATUS_W-1:0]     m_status,
    output logic [lfsa_pkg::DATA_W-1:0]       m_position,
    output logic [lfsa_pkg::REQ_IDX_W-1:0]    m_request_index
);
    import lfsa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     cfg_we;

    // single register: writes land on the cell count, reads decode address zero
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_W'(0)) ? stat.mem_size : '0;

    lfsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfsa_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (pwdata),
        .cmd             (cmd),
        .stat            (stat),
        .s_alloc_size    (s_alloc_size),
        .s_free_index    (s_free_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_position      (m_position),
        .m_request_index (m_request_index)
    );

    // failed allocations never carry a position
    a_fail_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_position == '0))
        else $error("failed allocation with nonzero position");

    // no undefined status code leaves the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_NOFIT || m_status == STAT_FULL))
        else $error("undefined status code");

    // one item in flight: the sequencer is busy right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while busy");

endmodule
